// File: design/lpfc_pkg.sv
// Shared types and constants of the length-prefixed frame checker.
package lpfc_pkg;

   localparam int TAG_BYTES = 8;
   localparam logic [16:0] ADLER_MOD = 17'd65521;

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 64;

   localparam logic [1:0] CSR_MAX_LENGTH = 2'd0;
   localparam logic [1:0] CSR_TAG_LENGTH = 2'd1;
   localparam logic [1:0] CSR_TAG_VALUE  = 2'd2;

   localparam logic [30:0] MAX_LENGTH_RESET = 31'd67108864;
   localparam logic [3:0]  TAG_LENGTH_RESET = 4'd0;
   localparam logic [63:0] TAG_VALUE_RESET  = 64'd0;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_BAD_LENGTH,
      STATUS_BAD_SUM,
      STATUS_BAD_TAG
   } status_type;

   typedef struct packed {
      logic [30:0] max_length;
      logic [3:0]  tag_length;
      logic [63:0] tag_value;
   } cfg_type;

   typedef struct packed {
      logic       is_status;
      logic [7:0] out_byte;
      status_type frame_status;
   } result_type;

   function automatic logic [3:0] eff_tag_length(input logic [3:0] tl);
      logic [3:0] r;
      r = (tl > 4'(TAG_BYTES)) ? 4'(TAG_BYTES) : tl;
      return r;
   endfunction

endpackage

// File: design/lpfc_csr.sv
// Configuration register file with APB-style access.
module lpfc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [lpfc_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [lpfc_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [lpfc_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output lpfc_pkg::cfg_type             cfg
);

   lpfc_pkg::cfg_type cfg_ff;
   lpfc_pkg::cfg_type cfg_in;
   logic [1:0]        reg_idx;
   logic              wr_en;

   assign reg_idx    = csr_paddr[4:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            lpfc_pkg::CSR_MAX_LENGTH: cfg_in.max_length = csr_pwdata[30:0];
            lpfc_pkg::CSR_TAG_LENGTH: cfg_in.tag_length = csr_pwdata[3:0];
            lpfc_pkg::CSR_TAG_VALUE:  cfg_in.tag_value  = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         lpfc_pkg::CSR_MAX_LENGTH: csr_prdata = {33'd0, cfg_ff.max_length};
         lpfc_pkg::CSR_TAG_LENGTH: csr_prdata = {60'd0, cfg_ff.tag_length};
         lpfc_pkg::CSR_TAG_VALUE:  csr_prdata = cfg_ff.tag_value;
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_length <= lpfc_pkg::MAX_LENGTH_RESET;
         cfg_ff.tag_length <= lpfc_pkg::TAG_LENGTH_RESET;
         cfg_ff.tag_value  <= lpfc_pkg::TAG_VALUE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/lpfc_front.sv
// Input side: two-entry byte queue between the stream and the frame engine.
module lpfc_front (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_in_byte,
   output logic       req_full,
   output logic       head_valid,
   output logic [7:0] head_byte,
   input  logic       head_pop
);

   logic [7:0] slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_in;
   logic [1:0] cnt_in;
   logic       enq;
   logic       deq;

   assign req_full   = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_byte  = slot_ff[rd_ptr_ff];
   assign enq        = req_push && !req_full;
   assign deq        = head_pop && head_valid;
   assign wr_ptr_in  = wr_ptr_ff ^ enq;
   assign rd_ptr_in  = rd_ptr_ff ^ deq;
   assign cnt_in     = cnt_ff + {1'b0, enq} - {1'b0, deq};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         slot_ff[wr_ptr_ff] <= req_in_byte;
      end
   end

endmodule

// File: design/lpfc_engine.sv
// Frame engine: length check, tag match, Adler-32 and the result queue.
module lpfc_engine (
   input  logic              clock,
   input  logic              reset,
   input  lpfc_pkg::cfg_type cfg,
   input  logic              head_valid,
   input  logic [7:0]        head_byte,
   output logic              head_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_is_status,
   output logic [7:0]        rsp_out_byte,
   output logic [1:0]        rsp_frame_status
);

   typedef enum logic [1:0] {
      ST_LENGTH,
      ST_BODY,
      ST_LOCKED
   } state_type;

   state_type   state_ff, state_in;
   logic [1:0]  sub_cnt_ff, sub_cnt_in;
   logic [23:0] len_sr_ff, len_sr_in;
   logic [30:0] body_len_ff, body_len_in;
   logic [30:0] byte_count_ff, byte_count_in;
   logic [15:0] sum_low_ff, sum_low_in;
   logic [15:0] sum_high_ff, sum_high_in;
   logic [23:0] exp_sum_ff, exp_sum_in;
   logic        tag_ok_ff, tag_ok_in;

   lpfc_pkg::result_type res;
   logic                 res_valid;
   logic                 take;
   logic [7:0]           b;
   logic [3:0]           eff_tl;
   logic [31:0]          len_w;
   logic [30:0]          min_len;
   logic [16:0]          lo_sum;
   logic [15:0]          lo_next;
   logic [16:0]          hi_sum;
   logic [15:0]          hi_next;
   logic [7:0]           want;

   lpfc_pkg::result_type q_ff [2];
   logic                 q_wr_ff;
   logic                 q_rd_ff;
   logic [1:0]           q_cnt_ff;
   logic [1:0]           q_cnt_in;
   logic                 q_deq;

   assign take     = head_valid && (q_cnt_ff != 2'd2);
   assign head_pop = take;
   assign b        = head_byte;
   assign eff_tl   = lpfc_pkg::eff_tag_length(cfg.tag_length);
   assign len_w    = {len_sr_ff, b};
   assign min_len  = {27'd0, eff_tl} + 31'd4;
   assign want     = cfg.tag_value[{byte_count_ff[2:0], 3'b000} +: 8];

   always_comb begin
      lo_sum  = {1'b0, sum_low_ff} + {9'd0, b};
      lo_next = (lo_sum >= lpfc_pkg::ADLER_MOD) ? 16'(lo_sum - lpfc_pkg::ADLER_MOD)
                                                : lo_sum[15:0];
      hi_sum  = {1'b0, sum_high_ff} + {1'b0, lo_next};
      hi_next = (hi_sum >= lpfc_pkg::ADLER_MOD) ? 16'(hi_sum - lpfc_pkg::ADLER_MOD)
                                                : hi_sum[15:0];
   end

   always_comb begin
      state_in      = state_ff;
      sub_cnt_in    = sub_cnt_ff;
      len_sr_in     = len_sr_ff;
      body_len_in   = body_len_ff;
      byte_count_in = byte_count_ff;
      sum_low_in    = sum_low_ff;
      sum_high_in   = sum_high_ff;
      exp_sum_in    = exp_sum_ff;
      tag_ok_in     = tag_ok_ff;
      res_valid     = 1'b0;
      res           = '{is_status: 1'b0, out_byte: 8'd0,
                        frame_status: lpfc_pkg::STATUS_OK};
      if (take) begin
         unique case (state_ff)
            ST_LENGTH: begin
               len_sr_in  = {len_sr_ff[15:0], b};
               sub_cnt_in = sub_cnt_ff + 2'd1;
               if (sub_cnt_ff == 2'd3) begin
                  if (len_w[31] || (len_w[30:0] > cfg.max_length) ||
                      (len_w[30:0] < min_len)) begin
                     state_in  = ST_LOCKED;
                     res_valid = 1'b1;
                     res       = '{is_status: 1'b1, out_byte: 8'd0,
                                   frame_status: lpfc_pkg::STATUS_BAD_LENGTH};
                  end else begin
                     state_in      = ST_BODY;
                     byte_count_in = '0;
                     body_len_in   = len_w[30:0] - 31'd4;
                  end
               end
            end
            ST_BODY: begin
               if (byte_count_ff == body_len_ff) begin
                  exp_sum_in = {exp_sum_ff[15:0], b};
                  sub_cnt_in = sub_cnt_ff + 2'd1;
                  if (sub_cnt_ff == 2'd3) begin
                     sub_cnt_in    = 2'd0;
                     byte_count_in = '0;
                     sum_low_in    = 16'd1;
                     sum_high_in   = 16'd0;
                     tag_ok_in     = 1'b1;
                     res_valid     = 1'b1;
                     res.is_status = 1'b1;
                     if ({sum_high_ff, sum_low_ff} != {exp_sum_ff, b}) begin
                        state_in         = ST_LOCKED;
                        res.frame_status = lpfc_pkg::STATUS_BAD_SUM;
                     end else if (!tag_ok_ff) begin
                        state_in         = ST_LOCKED;
                        res.frame_status = lpfc_pkg::STATUS_BAD_TAG;
                     end else begin
                        state_in         = ST_LENGTH;
                        res.frame_status = lpfc_pkg::STATUS_OK;
                     end
                  end
               end else begin
                  sum_low_in    = lo_next;
                  sum_high_in   = hi_next;
                  byte_count_in = byte_count_ff + 31'd1;
                  if (byte_count_ff < {27'd0, eff_tl}) begin
                     if (want != b) begin
                        tag_ok_in = 1'b0;
                     end
                  end else begin
                     res_valid    = 1'b1;
                     res.out_byte = b;
                  end
               end
            end
            ST_LOCKED: ;
            default: state_in = ST_LOCKED;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LENGTH;
         sub_cnt_ff    <= 2'd0;
         byte_count_ff <= '0;
         sum_low_ff    <= 16'd1;
         sum_high_ff   <= 16'd0;
         tag_ok_ff     <= 1'b1;
      end else begin
         state_ff      <= state_in;
         sub_cnt_ff    <= sub_cnt_in;
         byte_count_ff <= byte_count_in;
         sum_low_ff    <= sum_low_in;
         sum_high_ff   <= sum_high_in;
         tag_ok_ff     <= tag_ok_in;
      end
      len_sr_ff   <= len_sr_in;
      body_len_ff <= body_len_in;
      exp_sum_ff  <= exp_sum_in;
   end

   // result queue: two words deep
   assign q_deq            = rsp_pop && !rsp_empty;
   assign q_cnt_in         = q_cnt_ff + {1'b0, res_valid} - {1'b0, q_deq};
   assign rsp_empty        = (q_cnt_ff == 2'd0);
   assign rsp_is_status    = q_ff[q_rd_ff].is_status;
   assign rsp_out_byte     = q_ff[q_rd_ff].out_byte;
   assign rsp_frame_status = q_ff[q_rd_ff].frame_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= 1'b0;
         q_rd_ff  <= 1'b0;
         q_cnt_ff <= 2'd0;
      end else begin
         q_wr_ff  <= q_wr_ff ^ res_valid;
         q_rd_ff  <= q_rd_ff ^ q_deq;
         q_cnt_ff <= q_cnt_in;
      end
      if (res_valid) begin
         q_ff[q_wr_ff] <= res;
      end
   end

endmodule

// File: design/length_prefixed_frame_checker_top.sv
// Top level of the length-prefixed frame checker.
//
// Bytes enter on the req_ queue port: a byte is taken when req_push is high
// and req_full is low. Words leave on the rsp_ queue port: the oldest word
// stands on rsp_* while rsp_empty is low and is taken when rsp_pop is high.
// A word is either a payload byte (rsp_is_status low) or an end-of-frame
// status (ok, invalid length, checksum error, unknown tag).
// Length, tag and checksum bytes give no word, except that a bad length gives
// its status word on the fourth length byte; the fourth checksum byte gives the
// status word. After an error status all further bytes are taken and dropped until reset.
// A taken byte is registered in the input queue, then its word, if any, in the
// result queue. Throughput: one byte per cycle while the result queue has room,
// set by the engine's one-byte Adler-32 step.
// When the receiver stalls, the two-word result queue fills, the engine
// holds, the two-byte input queue fills and req_full rises.
// Reset empties both queues, returns registers to their reset values and
// restarts frame parsing at the length field.
// Registers sit on the csr_ port at byte addresses 0, 8 and 16.
module length_prefixed_frame_checker_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic [7:0]                    req_in_byte,
   output logic                          req_full,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic                          rsp_is_status,
   output logic [7:0]                    rsp_out_byte,
   output logic [1:0]                    rsp_frame_status,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [lpfc_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [lpfc_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [lpfc_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   lpfc_pkg::cfg_type cfg;
   logic              head_valid;
   logic [7:0]        head_byte;
   logic              head_pop;

   lpfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lpfc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_in_byte (req_in_byte),
      .req_full    (req_full),
      .head_valid  (head_valid),
      .head_byte   (head_byte),
      .head_pop    (head_pop)
   );

   lpfc_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .head_valid       (head_valid),
      .head_byte        (head_byte),
      .head_pop         (head_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_is_status    (rsp_is_status),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_frame_status (rsp_frame_status)
   );

endmodule

// File: design/lpfc_checker.sv
// Port-level checks of the frame checker, bound to the top level.
module lpfc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_is_status,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_frame_status
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_reset_not_full: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input queue full after reset");

   a_status_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_is_status) |-> (rsp_out_byte == 8'd0))
      else $error("status word carries a nonzero byte");

   a_payload_zero_status: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_is_status) |-> (rsp_frame_status == lpfc_pkg::STATUS_OK))
      else $error("payload word carries a nonzero status");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_is_status &&
       (rsp_frame_status != lpfc_pkg::STATUS_OK))
      |=> rsp_empty)
      else $error("word delivered after an error status");

endmodule

bind length_prefixed_frame_checker_top lpfc_checker u_lpfc_checker (.*);
